### hw/rtl/wmf_pkg.sv
// Shared constants, types and window mask functions for the window median filter.
package wmf_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HALF   = 3;
  localparam int PIXEL_BITS = 8;
  localparam int MAX_HEIGHT = 4096;

  // Derived widths
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int W_W      = COL_W + 1;
  localparam int H_W      = ROW_W + 1;
  localparam int HALF_W   = $clog2(MAX_HALF + 1);
  localparam int SIDE_W   = HALF_W + 1;
  localparam int SIDE_MAX = 2 * MAX_HALF + 1;
  localparam int CELLS    = SIDE_MAX * SIDE_MAX;
  localparam int MED_RANK = CELLS / 2;
  localparam int RANK_W   = $clog2(CELLS);

  // Line store: ring of banks, one image row per bank
  localparam int BANKS  = 16;
  localparam int BANK_W = $clog2(BANKS);

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;

  // Input operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Effective (clamped) geometry
  typedef struct packed {
    logic [W_W-1:0]    width;
    logic [H_W-1:0]    height;
    logic [HALF_W-1:0] half;
  } cfg_t;

  // Line store write from the front
  typedef struct packed {
    logic                  en;
    logic [BANK_W-1:0]     bank;
    logic [COL_W-1:0]      addr;
    logic [PIXEL_BITS-1:0] data;
  } wr_t;

  // One output position to be filtered
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BANK_W-1:0] bank;
    logic              last;
  } job_t;

  // Column read in flight in the back
  typedef struct packed {
    logic                              valid;
    logic                              clear;
    logic                              emit;
    logic                              last;
    logic                              colok;
    logic [SIDE_MAX-1:0]               rowok;
    logic [SIDE_MAX-1:0][BANK_W-1:0]   bsel;
  } rd_meta_t;

  // Cells of the full window that belong to the active square
  function automatic logic [CELLS-1:0] active_mask(input int half);
    logic [CELLS-1:0] m;
    int side;
    m    = '0;
    side = 2 * half + 1;
    for (int i = 0; i < SIDE_MAX; i++) begin
      for (int j = 0; j < SIDE_MAX; j++) begin
        m[i*SIDE_MAX+j] = (i < side) && (j >= SIDE_MAX - side);
      end
    end
    return m;
  endfunction

  // Unused cells: half forced to max, half to zero, so the middle stays put
  function automatic logic [CELLS-1:0] pad_hi_mask(input int half);
    logic [CELLS-1:0] m;
    int side;
    logic tog;
    m    = '0;
    side = 2 * half + 1;
    tog  = 1'b0;
    for (int i = 0; i < SIDE_MAX; i++) begin
      for (int j = 0; j < SIDE_MAX; j++) begin
        if (!((i < side) && (j >= SIDE_MAX - side))) begin
          m[i*SIDE_MAX+j] = tog;
          tog = !tog;
        end
      end
    end
    return m;
  endfunction

endpackage

### hw/rtl/window_median_filter_2d.sv
// Top level: configuration registers, line store banks, front, queue and back.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | in_operation, in_pixel_in
//  out_    | output    | out_valid / out_stall  | out_pixel_out, out_frame_done
//  config  | APB slave | psel, penable, pready  | paddr, pwdata, prdata
//
// One word accepted per cycle while in_stall is low; the back reads one line store column
// per cycle unless out_stall holds it, so each output row start prefills half_window extra
// window columns. Once the four-entry job queue has filled, the input stalls during prefill.
// A released result passes the column read, window, m1, m2 and out registers.
// rst_n is synchronous; a width, height or half write restarts the frame and drops pending work.
// in_stall rises only when the job queue is full; out_stall freezes the back pipeline.
module window_median_filter_2d (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [wmf_pkg::PIXEL_BITS-1:0]    in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wmf_pkg::PIXEL_BITS-1:0]    out_pixel_out,
  output logic                              out_frame_done,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wmf_pkg::ADDR_W-1:0]        paddr,
  input  logic [wmf_pkg::DATA_W-1:0]        pwdata,
  output logic [wmf_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [wmf_pkg::W_W-1:0]    frame_width_r;
  logic [wmf_pkg::H_W-1:0]    frame_height_r;
  logic [wmf_pkg::HALF_W-1:0] half_window_r;
  logic [1:0]                 ridx;
  logic                       wr_en, restart;
  wmf_pkg::cfg_t              cfg;

  logic                       acc, push, pop, q_empty, q_full, re;
  wmf_pkg::wr_t               wr;
  wmf_pkg::job_t              job, head;
  logic [wmf_pkg::COL_W-1:0]  raddr;
  logic [wmf_pkg::BANKS-1:0][wmf_pkg::PIXEL_BITS-1:0] rdata;

  // register port
  assign pready = 1'b1;
  assign ridx   = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    unique case (ridx)
      wmf_pkg::REG_WIDTH: begin
        restart = wr_en;
        prdata  = wmf_pkg::DATA_W'(frame_width_r);
      end
      wmf_pkg::REG_HEIGHT: begin
        restart = wr_en;
        prdata  = wmf_pkg::DATA_W'(frame_height_r);
      end
      wmf_pkg::REG_HALF: begin
        restart = wr_en;
        prdata  = wmf_pkg::DATA_W'(half_window_r);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= wmf_pkg::W_W'(640);
      frame_height_r <= wmf_pkg::H_W'(480);
      half_window_r  <= wmf_pkg::HALF_W'(1);
    end else if (wr_en) begin
      if (ridx == wmf_pkg::REG_WIDTH)  frame_width_r  <= pwdata[wmf_pkg::W_W-1:0];
      if (ridx == wmf_pkg::REG_HEIGHT) frame_height_r <= pwdata[wmf_pkg::H_W-1:0];
      if (ridx == wmf_pkg::REG_HALF)   half_window_r  <= pwdata[wmf_pkg::HALF_W-1:0];
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    cfg.width = frame_width_r;
    if (frame_width_r == '0) cfg.width = wmf_pkg::W_W'(1);
    else if (frame_width_r > wmf_pkg::W_W'(wmf_pkg::MAX_WIDTH))
      cfg.width = wmf_pkg::W_W'(wmf_pkg::MAX_WIDTH);
    cfg.height = frame_height_r;
    if (frame_height_r == '0) cfg.height = wmf_pkg::H_W'(1);
    else if (frame_height_r > wmf_pkg::H_W'(wmf_pkg::MAX_HEIGHT))
      cfg.height = wmf_pkg::H_W'(wmf_pkg::MAX_HEIGHT);
    cfg.half = half_window_r;
    if (half_window_r == '0) cfg.half = wmf_pkg::HALF_W'(1);
    else if (half_window_r > wmf_pkg::HALF_W'(wmf_pkg::MAX_HALF))
      cfg.half = wmf_pkg::HALF_W'(wmf_pkg::MAX_HALF);
  end

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;

  wmf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .cfg     (cfg),
    .acc     (acc),
    .op      (in_operation),
    .pix     (in_pixel_in),
    .wr      (wr),
    .push    (push),
    .job     (job)
  );

  wmf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .push    (push),
    .din     (job),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // line store: one bank per ring row
  for (genvar b = 0; b < wmf_pkg::BANKS; b++) begin : g_bank
    wmf_ram #(
      .WIDTH (wmf_pkg::PIXEL_BITS),
      .DEPTH (wmf_pkg::MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr.en && (wr.bank == wmf_pkg::BANK_W'(b))),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  wmf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .cfg        (cfg),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel_out),
    .out_done   (out_frame_done)
  );

endmodule

### hw/rtl/wmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/wmf_front.sv
// Front part: input counters, line store writes and result scheduling.
module wmf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  wmf_pkg::cfg_t                   cfg,
  input  logic                            acc,
  input  logic                            op,
  input  logic [wmf_pkg::PIXEL_BITS-1:0]  pix,
  output wmf_pkg::wr_t                    wr,
  output logic                            push,
  output wmf_pkg::job_t                   job
);

  logic [wmf_pkg::ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [wmf_pkg::COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [wmf_pkg::BANK_W-1:0] wbank_r, wbank_nxt, obank_r, obank_nxt;
  logic                       flush_r, flush_nxt;

  logic                       take_pix, row_end, frame_end, flush_mid, ready, last;
  logic [wmf_pkg::W_W-1:0]    col_inc, ocol_inc, lc, wm1;
  logic [wmf_pkg::H_W-1:0]    row_inc, lr, hm1;

  always_comb begin
    wm1      = cfg.width - 1'b1;
    hm1      = cfg.height - 1'b1;
    take_pix = acc && !flush_r && (op == wmf_pkg::OP_PIXEL);
    col_inc  = {1'b0, in_col_r} + 1'b1;
    row_inc  = {1'b0, in_row_r} + 1'b1;
    row_end  = col_inc >= cfg.width;
    frame_end = row_end && (row_inc >= cfg.height);

    // input position advance
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    wbank_nxt  = wbank_r;
    if (take_pix) begin
      if (row_end) begin
        in_col_nxt = '0;
        wbank_nxt  = wbank_r + 1'b1;
        in_row_nxt = frame_end ? '0 : row_inc[wmf_pkg::ROW_W-1:0];
      end else begin
        in_col_nxt = col_inc[wmf_pkg::COL_W-1:0];
      end
    end
    flush_mid = flush_r || (take_pix && frame_end);

    // last pixel that the window of the next output needs
    lr = {1'b0, out_row_r} + {{(wmf_pkg::H_W-wmf_pkg::HALF_W){1'b0}}, cfg.half};
    if (lr > hm1) lr = hm1;
    lc = {1'b0, out_col_r} + {{(wmf_pkg::W_W-wmf_pkg::HALF_W){1'b0}}, cfg.half};
    if (lc > wm1) lc = wm1;
    ready = flush_mid || (lr < {1'b0, in_row_nxt}) ||
            ((lr == {1'b0, in_row_nxt}) && (lc < {1'b0, in_col_nxt}));
    push  = acc && ready;
    last  = ({1'b0, out_row_r} == hm1) && ({1'b0, out_col_r} == wm1);

    // output position advance
    ocol_inc    = {1'b0, out_col_r} + 1'b1;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    obank_nxt   = obank_r;
    flush_nxt   = acc ? flush_mid : flush_r;
    if (push) begin
      if (last) begin
        out_row_nxt = '0;
        out_col_nxt = '0;
        obank_nxt   = obank_r + 1'b1;
        flush_nxt   = 1'b0;
      end else if (ocol_inc >= cfg.width) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
        obank_nxt   = obank_r + 1'b1;
      end else begin
        out_col_nxt = ocol_inc[wmf_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      wbank_r   <= '0;
      obank_r   <= '0;
      flush_r   <= 1'b0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      wbank_r   <= wbank_nxt;
      obank_r   <= obank_nxt;
      flush_r   <= flush_nxt;
    end
  end

  // line store write and job word
  assign wr.en   = take_pix;
  assign wr.bank = wbank_r;
  assign wr.addr = in_col_r;
  assign wr.data = pix;
  assign job.row  = out_row_r;
  assign job.col  = out_col_r;
  assign job.bank = obank_r;
  assign job.last = last;

endmodule

### hw/rtl/wmf_queue.sv
// Short job queue between the front and the back.
module wmf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          restart,
  input  logic          push,
  input  wmf_pkg::job_t din,
  input  logic          pop,
  output wmf_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  wmf_pkg::job_t            mem_r [wmf_pkg::QDEPTH];
  logic [wmf_pkg::QA_W-1:0] wp_r, rp_r;
  logic [wmf_pkg::QA_W:0]   cnt_r;

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (wmf_pkg::QA_W+1)'(wmf_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (wmf_pkg::QA_W+1)'(push) - (wmf_pkg::QA_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (wmf_pkg::QA_W+1)'(wmf_pkg::QDEPTH)) else $error("job queue count out of range");

endmodule

### hw/rtl/wmf_back.sv
// Back part: column reads, sliding window and pipelined rank-select median.
module wmf_back (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            restart,
  input  wmf_pkg::cfg_t                                   cfg,
  input  wmf_pkg::job_t                                   head,
  input  logic                                            head_valid,
  output logic                                            pop,
  output logic                                            re,
  output logic [wmf_pkg::COL_W-1:0]                       raddr,
  input  logic [wmf_pkg::BANKS-1:0][wmf_pkg::PIXEL_BITS-1:0] rdata,
  input  logic                                            out_stall,
  output logic                                            out_valid,
  output logic [wmf_pkg::PIXEL_BITS-1:0]                  out_pixel,
  output logic                                            out_done
);

  localparam int SM = wmf_pkg::SIDE_MAX;
  localparam int NC = wmf_pkg::CELLS;
  localparam int PB = wmf_pkg::PIXEL_BITS;

  logic                         adv, first, final_rd, issue;
  logic [wmf_pkg::HALF_W-1:0]   pcnt_r;
  logic [wmf_pkg::W_W-1:0]      rcol;
  logic [wmf_pkg::SIDE_W-1:0]   side;
  logic [wmf_pkg::H_W-1:0]      rr;
  wmf_pkg::rd_meta_t            meta, s1_r;

  logic [SM-1:0][SM-1:0][PB-1:0] win_r;
  logic [SM-1:0][PB-1:0]         colv;
  logic                          wv_valid_r, wv_last_r;

  logic [NC-1:0]                 act_tab [1:wmf_pkg::MAX_HALF];
  logic [NC-1:0]                 pad_tab [1:wmf_pkg::MAX_HALF];
  logic [NC-1:0]                 act, pad;
  logic [NC-1:0][PB-1:0]         vals, m1_vals_r, m2_vals_r;
  logic [NC-1:0][NC-1:0]         cmp, m1_cmp_r;
  logic [NC-1:0]                 sel, m2_sel_r;
  logic                          m1_valid_r, m1_last_r, m2_valid_r, m2_last_r;
  logic [PB-1:0]                 med, out_pixel_r;
  logic                          out_valid_r, out_done_r;

  // whole pipeline moves unless a held result is stalled
  assign adv = !(out_valid_r && out_stall);

  // column read issue: row start prefills half+1 columns, else one new column
  always_comb begin
    side     = {cfg.half, 1'b1};
    first    = (head.col == '0);
    rcol     = first ? {{(wmf_pkg::W_W-wmf_pkg::HALF_W){1'b0}}, pcnt_r}
                     : {1'b0, head.col} + {{(wmf_pkg::W_W-wmf_pkg::HALF_W){1'b0}}, cfg.half};
    final_rd = !first || (pcnt_r == cfg.half);
    issue    = head_valid && adv;
    pop      = issue && final_rd;
    re       = adv;
    raddr    = rcol[wmf_pkg::COL_W-1:0];

    meta.valid = issue;
    meta.clear = first && (pcnt_r == '0);
    meta.emit  = final_rd;
    meta.last  = head.last;
    meta.colok = rcol < cfg.width;
    for (int i = 0; i < SM; i++) begin
      rr = {1'b0, head.row} + wmf_pkg::H_W'(i);
      meta.rowok[i] = (wmf_pkg::SIDE_W'(i) < side) &&
                      (rr >= {{(wmf_pkg::H_W-wmf_pkg::HALF_W){1'b0}}, cfg.half}) &&
                      ((rr - {{(wmf_pkg::H_W-wmf_pkg::HALF_W){1'b0}}, cfg.half}) < cfg.height);
      meta.bsel[i]  = head.bank + wmf_pkg::BANK_W'(i) -
                      {{(wmf_pkg::BANK_W-wmf_pkg::HALF_W){1'b0}}, cfg.half};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pcnt_r <= '0;
    end else if (issue) begin
      pcnt_r <= final_rd ? '0 : pcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= meta;
    end
  end

  // pick each window row from its bank, zero outside the frame
  always_comb begin
    for (int i = 0; i < SM; i++) begin
      colv[i] = (s1_r.rowok[i] && s1_r.colok) ? rdata[s1_r.bsel[i]] : '0;
    end
  end

  // window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (adv && s1_r.valid) begin
      for (int i = 0; i < SM; i++) begin
        for (int j = 0; j < SM - 1; j++) begin
          win_r[i][j] <= s1_r.clear ? '0 : win_r[i][j+1];
        end
        win_r[i][SM-1] <= colv[i];
      end
    end
  end

  // cell masks for each window size
  for (genvar g = 1; g <= wmf_pkg::MAX_HALF; g++) begin : g_masks
    assign act_tab[g] = wmf_pkg::active_mask(g);
    assign pad_tab[g] = wmf_pkg::pad_hi_mask(g);
  end
  assign act = act_tab[cfg.half];
  assign pad = pad_tab[cfg.half];

  // rank compare: ties broken by cell index so ranks form a permutation
  always_comb begin
    for (int i = 0; i < SM; i++) begin
      for (int j = 0; j < SM; j++) begin
        vals[i*SM+j] = act[i*SM+j] ? win_r[i][j] : {PB{pad[i*SM+j]}};
      end
    end
    for (int k = 0; k < NC; k++) begin
      for (int j = 0; j < NC; j++) begin
        if (j < k)      cmp[k][j] = vals[j] <= vals[k];
        else if (j > k) cmp[k][j] = vals[j] < vals[k];
        else            cmp[k][j] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sel[k] = (wmf_pkg::RANK_W'($countones(m1_cmp_r[k])) ==
                wmf_pkg::RANK_W'(wmf_pkg::MED_RANK));
    end
    med = '0;
    for (int k = 0; k < NC; k++) begin
      med = med | (m2_sel_r[k] ? m2_vals_r[k] : '0);
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_vals_r   <= vals;
      m1_cmp_r    <= cmp;
      m1_last_r   <= wv_last_r;
      m2_vals_r   <= m1_vals_r;
      m2_sel_r    <= sel;
      m2_last_r   <= m1_last_r;
      wv_last_r   <= s1_r.last;
      out_pixel_r <= med;
      out_done_r  <= m2_last_r;
    end
  end

  // valid stages
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wv_valid_r  <= 1'b0;
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      wv_valid_r  <= s1_r.valid && s1_r.emit;
      m1_valid_r  <= wv_valid_r;
      m2_valid_r  <= m1_valid_r;
      out_valid_r <= m2_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_done  = out_done_r;

  a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
    m2_valid_r |-> $onehot(m2_sel_r)) else $error("median select not one-hot");
  a_prefill_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= cfg.half) else $error("prefill count beyond half window");
  a_prefill_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r != '0) |-> (head_valid && (head.col == '0)))
    else $error("prefill without a row-start job");

endmodule

### tb/wmf_checker.sv
// Scoreboard for the window median filter: tracks geometry, predicts each median word, compares.
module wmf_checker
  import wmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_operation,
  input  logic [PIXEL_BITS-1:0] in_pixel_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIXEL_BITS-1:0] out_pixel_out,
  input  logic                  out_frame_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 2 * MAX_HALF + 2;

  typedef struct {
    logic [PIXEL_BITS-1:0] pix;
    logic                  done;
  } median_word_t;

  median_word_t medians_due[$];

  // Model copy of registers and frame position
  logic [10:0]           width_reg;
  logic [12:0]           height_reg;
  logic [1:0]            half_reg;
  int                    src_row, src_col, dst_row, dst_col;
  bit                    draining;
  logic [PIXEL_BITS-1:0] line_mem [RING*MAX_WIDTH];

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int eff_half();
    int k;
    k = half_reg;
    if (k < 1) k = 1;
    if (k > MAX_HALF) k = MAX_HALF;
    return k;
  endfunction

  function automatic void restart_frame();
    src_row  = 0;
    src_col  = 0;
    dst_row  = 0;
    dst_col  = 0;
    draining = 0;
  endfunction

  // Median of the zero-padded window around the next output position
  function automatic logic [PIXEL_BITS-1:0] window_median(int w, int h, int k);
    int vals [CELLS];
    int n, r, c, v, j;
    n = 0;
    for (int i = -k; i <= k; i++) begin
      for (int m = -k; m <= k; m++) begin
        r = dst_row + i;
        c = dst_col + m;
        if (r < 0 || c < 0 || r >= h || c >= w) v = 0;
        else v = line_mem[(r % RING) * MAX_WIDTH + c];
        j = n;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
        n++;
      end
    end
    return PIXEL_BITS'(vals[n/2]);
  endfunction

  // One accepted input word: store the pixel, maybe emit one median
  function automatic void accept_word(logic op, logic [PIXEL_BITS-1:0] pix);
    int w, h, k, lr, lc;
    bit ready;
    median_word_t mw;
    w = eff_width();
    h = eff_height();
    k = eff_half();
    if (!draining && op == OP_PIXEL) begin
      line_mem[(src_row % RING) * MAX_WIDTH + src_col] = pix;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
        if (src_row >= h) begin
          src_row  = 0;
          draining = 1;
        end
      end
    end
    if (draining) ready = 1;
    else begin
      lr = dst_row + k;
      lc = dst_col + k;
      if (lr > h - 1) lr = h - 1;
      if (lc > w - 1) lc = w - 1;
      ready = (lr * w + lc) < (src_row * w + src_col);
    end
    if (!ready) return;
    mw.pix  = window_median(w, h, k);
    mw.done = (dst_row == h - 1) && (dst_col == w - 1);
    medians_due.push_back(mw);
    if (mw.done) begin
      dst_row  = 0;
      dst_col  = 0;
      draining = 0;
    end else begin
      dst_col++;
      if (dst_col >= w) begin
        dst_col = 0;
        dst_row++;
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    median_word_t mw;
    if (!rst_n) begin
      width_reg  = 11'd640;
      height_reg = 13'd480;
      half_reg   = 2'd1;
      restart_frame();
      medians_due.delete();
    end else begin
      // register write restarts the frame
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:  width_reg  = pwdata[10:0];
          REG_HEIGHT: height_reg = pwdata[12:0];
          REG_HALF:   half_reg   = pwdata[1:0];
          default: ;
        endcase
        if (paddr[3:2] <= REG_HALF) restart_frame();
      end
      if (in_valid && !in_stall) accept_word(in_operation, in_pixel_in);
      if (out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word pix=%0d done=%0b",
                                    out_pixel_out, out_frame_done));
        end else begin
          mw = medians_due.pop_front();
          if (out_pixel_out !== mw.pix)
            report_mismatch($sformatf("pixel_out %0d, want %0d", out_pixel_out, mw.pix));
          if (out_frame_done !== mw.done)
            report_mismatch($sformatf("frame_done %0b, want %0b", out_frame_done, mw.done));
        end
      end
    end
    outstanding <= medians_due.size();
  end

endmodule

### tb/tb_window_median_filter_2d.sv
// Testbench top: clock, reset, register writes, pixel stimulus and the verdict.
module tb_window_median_filter_2d;
  import wmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_stall;
  logic                  in_operation = OP_PIXEL;
  logic [PIXEL_BITS-1:0] in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_stall = 0;
  logic [PIXEL_BITS-1:0] out_pixel_out;
  logic                  out_frame_done;
  logic                  psel = 0;
  logic                  penable = 0;
  logic                  pwrite = 0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  int                    errors, outstanding;
  int                    words_sent = 0;
  int                    cur_w = 640, cur_h = 480, cur_k = 1;

  always #6 clk = ~clk;

  window_median_filter_2d dut (.*);

  wmf_checker chk (.*);

  // Result side back-pressure: short and long stalls, plus free-running stretches
  int stall_hold = 0;
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        out_stall  <= 0;
        stall_hold = $urandom_range(50, 200);
      end else begin
        out_stall  <= ($urandom_range(0, 2) == 0);
        stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 4);
      end
    end else begin
      stall_hold--;
    end
  end

  // APB write: setup cycle then access cycle
  task automatic reg_write(logic [1:0] idx, int unsigned value, int unsigned keep);
    @(posedge clk);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & keep) | ($urandom & ~keep);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // Wait until every median has arrived, then let the pipeline settle
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h, int k);
    settle();
    reg_write(REG_WIDTH, w, 32'h7FF);
    reg_write(REG_HEIGHT, h, 32'h1FFF);
    reg_write(REG_HALF, k, 32'h3);
    cur_w = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    cur_k = (k < 1) ? 1 : (k > MAX_HALF) ? MAX_HALF : k;
  endtask

  // Drive one word; valid stays high across back-to-back words
  task automatic send_word(logic op, logic [PIXEL_BITS-1:0] pix);
    int gap;
    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
        : ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1;
    in_operation <= op;
    in_pixel_in  <= pix;
    // accepted at the first edge that sees stall low
    @(posedge clk iff !in_stall);
    words_sent++;
  endtask

  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return PIXEL_BITS'($urandom_range(100, 104));
      default: return PIXEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Pixels for a frame (or part of one), sprinkled drains, then flush words
  task automatic run_frame(int npix, bit noisy);
    int tail;
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_word(OP_DRAIN, pick_pixel());
      send_word(OP_PIXEL, pick_pixel());
    end
    // results still pending never exceed the lag of the first window
    tail = ((cur_k < cur_h - 1) ? cur_k : cur_h - 1) * cur_w +
           ((cur_k < cur_w - 1) ? cur_k : cur_w - 1) + 2;
    if (tail > cur_w * cur_h + 1) tail = cur_w * cur_h + 1;
    // during flush, pixel words act as drains
    for (int i = 0; i < tail; i++)
      send_word(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN, pick_pixel());
  endtask

  initial begin
    int w, h, k, n;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed: reset geometry, partial frame of extremes
    for (int i = 0; i < 12; i++) send_word(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00);
    send_word(OP_DRAIN, 8'hFF);
    set_geometry(3, 3, 1);
    run_frame(9, 0);
    set_geometry(0, 0, 0);
    run_frame(1, 0);
    set_geometry(4, 2, 3);
    run_frame(8, 1);
    set_geometry(2047, 1, 3);
    run_frame(1024, 1);
    set_geometry(1, 8191, 1);
    run_frame(200, 0);
    set_geometry(7, 5, 2);
    run_frame(35, 1);

    // Random geometries, mostly small, some frames cut short
    n = 0;
    while (n < 500) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      k = $urandom_range(0, 3);
      set_geometry(w, h, k);
      if ($urandom_range(0, 4) == 0) begin
        run_frame($urandom_range(0, cur_w * cur_h - 1), 1);
        n += cur_w * cur_h / 2;
      end else begin
        run_frame(cur_w * cur_h, 1);
        n += cur_w * cur_h;
      end
    end

    settle();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
hw/rtl/wmf_pkg.sv
hw/rtl/wmf_ram.sv
hw/rtl/wmf_front.sv
hw/rtl/wmf_queue.sv
hw/rtl/wmf_back.sv
hw/rtl/window_median_filter_2d.sv
tb/wmf_checker.sv
tb/tb_window_median_filter_2d.sv
